// ===== hdl/tssp_pkg.sv =====
package tssp_pkg;

	localparam int DAY_W      = 27;
	localparam int STAMP_W    = 48;
	localparam int TIME_W     = 16;
	localparam int SKEW_W     = 17;
	localparam int COUNT_W    = 3;
	localparam int SLOT_W     = 2;
	localparam int SLOTS      = 4;
	localparam int MAX_SLOTS  = 4;
	localparam int ROUND_W    = TIME_W + 2;
	localparam int SUM_W      = DAY_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = SKEW_W;
	localparam int DIGIT_W    = 2;
	localparam int DIGITS     = STAMP_W / DIGIT_W;

	localparam logic [SUM_W-1:0] DAY_MS = SUM_W'(86400000);

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_ZERO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_ONE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_TWO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_THREE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_IVL   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SKEW  = 3'd6;

	typedef logic [TIME_W-1:0]  ms_t;
	typedef logic [SLOT_W-1:0]  slot_t;
	typedef logic [DAY_W-1:0]   day_t;
	typedef logic [STAMP_W-1:0] stamp_t;
	typedef logic [ROUND_W-1:0] round_t;

	typedef struct packed {
		logic div_busy;
		logic cmp_busy;
	} unit_stat_t;

endpackage

// ===== hdl/tssp_if.sv =====
interface tssp_in_if;
	import tssp_pkg::*;
	logic   valid;
	logic   ready;
	day_t   day_time_ms;
	stamp_t stamp_ms;
	modport source (output valid, output day_time_ms, output stamp_ms, input ready);
	modport sink   (input valid, input day_time_ms, input stamp_ms, output ready);
endinterface

interface tssp_out_if;
	import tssp_pkg::*;
	logic  valid;
	logic  ready;
	slot_t slot_index;
	ms_t   slot_length_ms;
	logic  realigned;
	logic  slot_changed;
	slot_t previous_slot;
	logic  first_slot_reached;
	logic  idle;
	modport source (output valid, output slot_index, output slot_length_ms, output realigned,
		output slot_changed, output previous_slot, output first_slot_reached, output idle,
		input ready);
	modport sink   (input valid, input slot_index, input slot_length_ms, input realigned,
		input slot_changed, input previous_slot, input first_slot_reached, input idle,
		output ready);
endinterface

// ===== hdl/tssp_div.sv =====
module tssp_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  tssp_pkg::day_t          dividend,
	input  tssp_pkg::round_t        divisor,
	output tssp_pkg::round_t        remainder,
	output logic                    busy
);
	import tssp_pkg::*;

	localparam int CNT_W = $clog2(DAY_W);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	round_t           rem_q;
	day_t             dvd_q;
	round_t           dvs_q;
	logic [ROUND_W:0] trial;
	logic [ROUND_W:0] diff;

	assign trial = {rem_q, dvd_q[DAY_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(DAY_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DAY_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[ROUND_W-1:0];
			end else begin
				rem_q <= trial[ROUND_W-1:0];
			end
		end
	end

	assign remainder = rem_q;
	assign busy      = busy_q;

endmodule

// ===== hdl/tssp_cmp.sv =====
module tssp_cmp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  tssp_pkg::stamp_t stamp,
	input  logic             start,
	input  tssp_pkg::ms_t    interval,
	input  logic             commit,
	output logic             elapsed,
	output logic             busy
);
	import tssp_pkg::*;

	localparam int CNT_W = $clog2(DIGITS);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	stamp_t           stamp_q;
	stamp_t           last_q;
	ms_t              ivl_q;
	logic             bor_q;
	logic             gt_q;
	logic             bor_d;
	logic             gt_d;

	always_comb begin
		logic a;
		logic b;
		logic d;
		logic i;
		bor_d = bor_q;
		gt_d  = gt_q;
		for (int k = 0; k < DIGIT_W; k++) begin
			a     = stamp_q[k];
			b     = last_q[k];
			i     = ivl_q[k];
			d     = a ^ b ^ bor_d;
			bor_d = (~a & b) | (~(a ^ b) & bor_d);
			gt_d  = (d & ~i) | (~(d ^ i) & gt_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			last_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 1'b1;
			last_q <= {last_q[DIGIT_W-1:0], last_q[STAMP_W-1:DIGIT_W]};
			if (cnt_q == CNT_W'(DIGITS - 1)) begin
				busy_q <= 1'b0;
			end
		end else if (commit) begin
			last_q <= stamp_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			stamp_q <= stamp;
		end else if (busy_q) begin
			stamp_q <= {stamp_q[DIGIT_W-1:0], stamp_q[STAMP_W-1:DIGIT_W]};
		end
		if (start) begin
			ivl_q <= interval;
			bor_q <= 1'b0;
			gt_q  <= 1'b0;
		end else if (busy_q) begin
			ivl_q <= {DIGIT_W'(0), ivl_q[TIME_W-1:DIGIT_W]};
			bor_q <= bor_d;
			gt_q  <= gt_d;
		end
	end

	assign elapsed = gt_q;
	assign busy    = busy_q;

endmodule

// ===== hdl/time_slot_phase_scheduler.sv =====
// Round-robin time-division slot scheduler.
// in_ch takes one phase-end beat (time of day, free-running ms stamp); out_ch
// gives one result beat per input beat: next slot, its length and the marks.
// cfg_we/cfg_index/cfg_data write the seven registers in list order; write them
// only while no beat is in flight.
// Each result comes from the 27-step bit-serial remainder of the day time by the
// round length, then a slot search. The 48-bit stamp difference is compared two
// bits a cycle alongside the remainder. With no slots configured the beat goes
// straight from idle to the final state.
// One beat is worked on at a time; in_ch.ready rises again at the edge that
// loads the result into the output register, so a new beat is taken while an
// earlier result waits.
// Stall: a result held by a low out_ch.ready blocks only the next result; the
// next beat still computes and then waits in its final state.
// Reset: registers return to count 0, durations 100, interval 1000, skew 0;
// current slot 0 and the first beat with slots configured always realigns.
module time_slot_phase_scheduler (
	input  logic                        clk,
	input  logic                        arst_n,
	tssp_in_if.sink                     in_ch,
	tssp_out_if.source                  out_ch,
	input  logic                        cfg_we,
	input  logic [tssp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tssp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tssp_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WRAP  = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_RUN   = 3'd3;
	localparam logic [2:0] S_SRCH  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]         state_q;
	logic [COUNT_W-1:0] count_q;
	ms_t                time_q [SLOTS];
	ms_t                ivl_q;
	logic [SKEW_W-1:0]  skew_q;

	slot_t              cur_q;
	logic               never_q;
	logic               empty_q;
	logic [SUM_W-1:0]   sum_q;
	day_t               t_q;
	round_t             round_q;
	round_t             into_q;
	round_t             cumul_q;
	slot_t              found_q;

	logic               ovalid_q;
	slot_t              oslot_q;
	ms_t                olen_q;
	logic               oalign_q;
	logic               ochg_q;
	slot_t              oprev_q;
	logic               ofirst_q;
	logic               oidle_q;

	logic [COUNT_W-1:0] n_eff;
	logic               accept;
	logic               unit_start;
	logic               out_free;
	logic               align;
	logic               commit;
	slot_t              nxt;
	slot_t              new_slot;
	ms_t                new_len;
	logic [COUNT_W-1:0] step;
	logic [SUM_W-1:0]   t_wide;
	round_t             round_d;
	round_t             rem;
	round_t             cumul_next;
	slot_t              found_next;
	logic               elapsed;
	unit_stat_t         stat;

	assign n_eff      = (count_q > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS) : count_q;
	assign accept     = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE);
	assign unit_start = (state_q == S_START);
	assign out_free   = !ovalid_q || out_ch.ready;
	assign align      = never_q || elapsed;
	assign commit     = (state_q == S_DONE) && out_free && !empty_q && align;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int k = 0; k < SLOTS; k++) begin
				time_q[k] <= TIME_W'(100);
			end
			ivl_q  <= TIME_W'(1000);
			skew_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SLOT_COUNT: count_q   <= cfg_data[COUNT_W-1:0];
				CFG_SLOT_ZERO:  time_q[0] <= cfg_data[TIME_W-1:0];
				CFG_SLOT_ONE:   time_q[1] <= cfg_data[TIME_W-1:0];
				CFG_SLOT_TWO:   time_q[2] <= cfg_data[TIME_W-1:0];
				CFG_SLOT_THREE: time_q[3] <= cfg_data[TIME_W-1:0];
				CFG_ALIGN_IVL:  ivl_q     <= cfg_data[TIME_W-1:0];
				CFG_CLOCK_SKEW: skew_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// wrap into one day and sum the round
	always_comb begin
		if (sum_q[SUM_W-1]) begin
			t_wide = sum_q + DAY_MS;
		end else if (sum_q >= DAY_MS) begin
			t_wide = sum_q - DAY_MS;
		end else begin
			t_wide = sum_q;
		end
		round_d = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (COUNT_W'(k) < n_eff) begin
				round_d = round_d + {2'b00, time_q[k]};
			end
		end
	end

	assign step       = {1'b0, found_q} + 1'b1;
	assign found_next = step[SLOT_W-1:0];
	assign cumul_next = cumul_q + {2'b00, time_q[found_next]};

	always_comb begin
		logic [COUNT_W-1:0] inc;
		inc = {1'b0, cur_q} + 1'b1;
		nxt = (inc >= n_eff) ? '0 : inc[SLOT_W-1:0];
		if (align) begin
			new_slot = found_q;
			new_len  = (cumul_q >= into_q) ? TIME_W'(cumul_q - into_q) : '0;
		end else begin
			new_slot = nxt;
			new_len  = time_q[nxt];
		end
	end

	tssp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (unit_start),
		.dividend  (t_q),
		.divisor   (round_q),
		.remainder (rem),
		.busy      (stat.div_busy)
	);

	tssp_cmp u_cmp (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.stamp    (in_ch.stamp_ms),
		.start    (unit_start),
		.interval (ivl_q),
		.commit   (commit),
		.elapsed  (elapsed),
		.busy     (stat.cmp_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cur_q    <= '0;
			never_q  <= 1'b1;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (n_eff == '0) ? S_DONE : S_WRAP;
					end
				end
				S_WRAP:  state_q <= S_START;
				S_START: state_q <= S_RUN;
				S_RUN: begin
					if (!stat.div_busy && !stat.cmp_busy) begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (!(step < n_eff && cumul_q < into_q)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q  <= S_IDLE;
						if (empty_q) begin
							cur_q <= '0;
						end else begin
							cur_q <= new_slot;
							if (align) begin
								never_q <= 1'b0;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			empty_q <= (n_eff == '0);
			sum_q   <= {2'b00, in_ch.day_time_ms}
				+ {{(SUM_W - SKEW_W){skew_q[SKEW_W-1]}}, skew_q};
		end
		if (state_q == S_WRAP) begin
			t_q     <= t_wide[DAY_W-1:0];
			round_q <= round_d;
		end
		if (state_q == S_RUN) begin
			into_q  <= (round_q == '0) ? '0 : rem;
			found_q <= '0;
			cumul_q <= {2'b00, time_q[0]};
		end
		if (state_q == S_SRCH && step < n_eff && cumul_q < into_q) begin
			found_q <= found_next;
			cumul_q <= cumul_next;
		end
		if (state_q == S_DONE && out_free) begin
			oprev_q <= cur_q;
			if (empty_q) begin
				oslot_q  <= '0;
				olen_q   <= '0;
				oalign_q <= 1'b0;
				ochg_q   <= 1'b0;
				ofirst_q <= 1'b0;
				oidle_q  <= 1'b1;
			end else begin
				oslot_q  <= new_slot;
				olen_q   <= new_len;
				oalign_q <= align;
				ochg_q   <= (new_slot != cur_q);
				ofirst_q <= (new_slot != cur_q) && (new_slot == '0);
				oidle_q  <= 1'b0;
			end
		end
	end

	assign out_ch.valid              = ovalid_q;
	assign out_ch.slot_index         = oslot_q;
	assign out_ch.slot_length_ms     = olen_q;
	assign out_ch.realigned          = oalign_q;
	assign out_ch.slot_changed       = ochg_q;
	assign out_ch.previous_slot      = oprev_q;
	assign out_ch.first_slot_reached = ofirst_q;
	assign out_ch.idle               = oidle_q;

endmodule

// ===== hdl/tssp_chk.sv =====
module tssp_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input tssp_pkg::slot_t       slot_index,
	input tssp_pkg::ms_t         slot_length_ms,
	input logic                  realigned,
	input logic                  slot_changed,
	input tssp_pkg::slot_t       previous_slot,
	input logic                  first_slot_reached,
	input logic                  idle
);
	import tssp_pkg::*;

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a beat is in flight");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot_index) && $stable(slot_length_ms))
		else $error("stalled result changed");

	a_idle_marks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle |-> slot_index == '0 && slot_length_ms == '0 && !realigned
			&& !slot_changed && !first_slot_reached)
		else $error("idle result carries a slot");

	a_changed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !idle |-> slot_changed == (slot_index != previous_slot))
		else $error("change mark disagrees with slots");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_slot_reached |-> slot_changed && slot_index == '0)
		else $error("first slot mark without change to slot zero");

endmodule

bind time_slot_phase_scheduler tssp_chk u_tssp_chk (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_ch.valid),
	.in_ready           (in_ch.ready),
	.out_valid          (out_ch.valid),
	.out_ready          (out_ch.ready),
	.slot_index         (out_ch.slot_index),
	.slot_length_ms     (out_ch.slot_length_ms),
	.realigned          (out_ch.realigned),
	.slot_changed       (out_ch.slot_changed),
	.previous_slot      (out_ch.previous_slot),
	.first_slot_reached (out_ch.first_slot_reached),
	.idle               (out_ch.idle)
);
